[hdl/sorted_table_equal_range_assert.svh]
// Assertion macros shared by the RTL of the sorted table search block.
`ifndef SORTED_TABLE_EQUAL_RANGE_ASSERT_SVH
`define SORTED_TABLE_EQUAL_RANGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STER_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define STER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

[hdl/ster_pkg.sv]
`timescale 1ns / 1ps

package ster_pkg;

    // Fixed field widths of the channels and the length register.
    localparam int LEN_W  = 11;
    localparam int SLOT_W = 10;
    localparam int KEY_W  = 32;

    // Defaults of the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    // Item kinds carried in the mode field.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[hdl/ster_in_if.sv]
`timescale 1ns / 1ps

interface ster_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [ster_pkg::SLOT_W-1:0] slot;
    logic [ster_pkg::KEY_W-1:0]  key;

    modport source (output valid, output mode, output slot, output key, input ready);
    modport sink   (input valid, input mode, input slot, input key, output ready);
endinterface

[hdl/ster_out_if.sv]
`timescale 1ns / 1ps

interface ster_out_if;
    logic                       valid;
    logic                       ready;
    logic [ster_pkg::LEN_W-1:0] lower_index;
    logic [ster_pkg::LEN_W-1:0] upper_index;

    modport source (output valid, output lower_index, output upper_index, input ready);
    modport sink   (input valid, input lower_index, input upper_index, output ready);
endinterface

[hdl/sorted_table_equal_range.sv]
`timescale 1ns / 1ps

// Equal-range search over a table of ascending unsigned keys held in one
// synchronous memory (one write port, one registered read port).
// A load item writes its key at its slot when it is taken and gives no
// result; a slot at or beyond TABLE_DEPTH is dropped. A query item gives one
// result, the lower and upper bound of its key within the first table_length
// entries (saturated to TABLE_DEPTH). The search is a three-way binary search;
// on the first equal probe it continues with a lower-bound search left of that
// probe and then an upper-bound search right of it. The read port does one
// probe per clock while a search phase runs, and the block stays busy with a
// query until its result is in the output register. Items are taken one at
// a time: the input is ready only while no query is in progress. Results
// leave through an output register, so a new item may be accepted while the
// last result still waits for its transfer. Entries that queries reach must
// have been loaded first; the memory has no reset. table_length must be
// written through the configuration port only while the block is idle; the
// block itself does not enforce this.
module sorted_table_equal_range #(
    parameter int TABLE_DEPTH = ster_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = ster_pkg::DEF_KEY_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ster_pkg::LEN_W-1:0]  i_cfg_data,
    ster_in_if.sink                     i_item,
    ster_out_if.source                  o_result
);
    import ster_pkg::*;

    // Address width of the memory, and the largest count a query can search.
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIM = (TABLE_DEPTH > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : TABLE_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_THREE,
        PH_LOWER,
        PH_UPPER
    } t_phase;

    // Key memory.
    logic [KEY_WIDTH-1:0] mem [0:TABLE_DEPTH-1];
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;

    // Control and search registers.
    t_state               r_state;
    t_phase               r_phase;
    logic [LEN_W-1:0]     r_len;
    logic [KEY_WIDTH-1:0] r_key;
    logic [LEN_W-1:0]     r_base;
    logic [LEN_W-1:0]     r_n;
    logic [LEN_W-1:0]     r_half;
    logic [LEN_W-1:0]     r_mid;
    logic [LEN_W-1:0]     r_up_base;
    logic [LEN_W-1:0]     r_up_n;
    logic [LEN_W-1:0]     r_lo_res;
    logic [LEN_W-1:0]     r_hi_res;
    logic                 r_out_valid;
    logic [LEN_W-1:0]     r_out_lo;
    logic [LEN_W-1:0]     r_out_hi;

    // Combinational next values.
    logic                 item_xfer;
    logic                 out_free;
    logic [LEN_W-1:0]     n_first;
    logic [LEN_W-1:0]     probe_half;
    logic [LEN_W-1:0]     probe_mid;
    logic                 key_lt;
    logic                 key_gt;
    logic                 hit_first;
    logic [LEN_W-1:0]     right_base;
    logic [LEN_W-1:0]     right_n;
    logic [LEN_W-1:0]     n_base;
    logic [LEN_W-1:0]     n_n;
    t_phase               n_phase;
    logic [LEN_W-1:0]     n_half;
    logic [LEN_W-1:0]     n_mid;

    assign i_item.ready = (r_state == S_IDLE);
    assign item_xfer    = i_item.valid && (r_state == S_IDLE);
    assign out_free     = !r_out_valid || o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.lower_index = r_out_lo;
    assign o_result.upper_index = r_out_hi;

    // A load writes straight into the memory in the cycle of its transfer.
    assign mem_we  = item_xfer && (i_item.mode == MODE_LOAD)
                     && (32'(i_item.slot) < TABLE_DEPTH);
    assign wr_addr = AW'(i_item.slot);

    // The searched count saturates at the table depth.
    assign n_first = (r_len > LEN_W'(LIM)) ? LEN_W'(LIM) : r_len;

    // Probe point of the current range when a phase starts or resumes.
    assign probe_half = r_n >> 1;
    assign probe_mid  = r_base + probe_half;

    // Compare the key read at r_mid and narrow the range. When the narrowed
    // range is not empty its next probe is issued in the same cycle.
    always_comb begin
        key_lt     = r_rd_data < r_key;
        key_gt     = r_key < r_rd_data;
        right_base = r_mid + LEN_W'(1);
        right_n    = r_n - r_half - LEN_W'(1);
        hit_first  = 1'b0;
        n_base     = r_base;
        n_n        = r_half;
        n_phase    = r_phase;
        case (r_phase)
            PH_THREE: begin
                if (key_lt) begin
                    n_base = right_base;
                    n_n    = right_n;
                end else if (!key_gt) begin
                    // First equal key: search left for the lower bound,
                    // keep the right part for the upper bound.
                    hit_first = 1'b1;
                    n_phase   = PH_LOWER;
                end
            end
            PH_LOWER: begin
                if (key_lt) begin
                    n_base = right_base;
                    n_n    = right_n;
                end
            end
            PH_UPPER: begin
                if (!key_gt) begin
                    n_base = right_base;
                    n_n    = right_n;
                end
            end
            default: begin
                n_base = r_base;
                n_n    = r_half;
            end
        endcase
        n_half = n_n >> 1;
        n_mid  = n_base + n_half;
    end

    assign rd_addr = (r_state == S_CMP) ? AW'(n_mid) : AW'(probe_mid);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= KEY_WIDTH'(i_item.key);
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_THREE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            // In S_DONE the output register is either kept or reloaded below.
            if (r_out_valid && o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (item_xfer && (i_item.mode == MODE_QUERY)) begin
                        r_key   <= KEY_WIDTH'(i_item.key);
                        r_base  <= '0;
                        r_n     <= n_first;
                        r_phase <= PH_THREE;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_n == '0) begin
                        case (r_phase)
                            PH_THREE: begin
                                // No equal key: both bounds are the insertion point.
                                r_lo_res <= r_base;
                                r_hi_res <= r_base;
                                r_state  <= S_DONE;
                            end
                            PH_LOWER: begin
                                r_lo_res <= r_base;
                                r_base   <= r_up_base;
                                r_n      <= r_up_n;
                                r_phase  <= PH_UPPER;
                            end
                            default: begin
                                r_hi_res <= r_base;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_half  <= probe_half;
                        r_mid   <= probe_mid;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_base  <= n_base;
                    r_n     <= n_n;
                    r_phase <= n_phase;
                    r_half  <= n_half;
                    r_mid   <= n_mid;
                    if (hit_first) begin
                        r_up_base <= right_base;
                        r_up_n    <= right_n;
                    end
                    if (n_n == '0) begin
                        r_state <= S_PROBE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_lo    <= r_lo_res;
                        r_out_hi    <= r_hi_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the search datapath and the result hand-off.
`include "sorted_table_equal_range_assert.svh"

    `STER_ASSERT_IMPLY(a_cmp_probe_consistent, i_clk, i_rst_n, r_state == S_CMP, (r_n != '0) && (r_mid == r_base + r_half))
    `STER_ASSERT_IMPLY(a_range_within_limit, i_clk, i_rst_n, (r_state == S_PROBE) || (r_state == S_CMP), ({1'b0, r_base} + {1'b0, r_n}) <= (LEN_W + 1)'(LIM))
    `STER_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, (r_state == S_DONE) && out_free, r_out_valid && (r_state == S_IDLE))
    `STER_ASSERT_IMPLY(a_bounds_ordered, i_clk, i_rst_n, r_out_valid, r_out_lo <= r_out_hi)

endmodule

[bench/sorted_table_equal_range_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the sorted table equal-range search block.
// Items go in through a valid/ready channel and results come back through another.
// The bench keeps its own copy of the key table and the search length.
// Every query that the block accepts is searched here the same way, and the bounds
// it yields are queued. Each result transfer is checked against the oldest entry
// in that queue. Loads give no result and only update the local table copy.
module sorted_table_equal_range_tb;

    import ster_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;

    // This many quiet cycles after the last result guarantee that the block is idle.
    localparam int SETTLE_CYCLES = 40;

    // The limit lies above the slowest correct run: every item waits its longest
    // gap, the search takes its longest path and the receiver stalls its longest.
    localparam int CYCLE_LIMIT = 600000;

    // No new random phase starts once this many items in total have been sent.
    localparam int ITEM_GOAL = 1900;

    typedef struct packed {
        logic [LEN_W-1:0] lower_index;
        logic [LEN_W-1:0] upper_index;
    } key_range_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LEN_W-1:0] i_cfg_data;

    ster_in_if  item_if ();
    ster_out_if result_if ();

    sorted_table_equal_range #(
        .TABLE_DEPTH (DEF_TABLE_DEPTH),
        .KEY_WIDTH   (DEF_KEY_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the block's state. The table copy is only meaningful for
    // entries that were loaded, and the stimulus never lets a search reach the rest.
    logic [KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [LEN_W-1:0] search_length;

    key_range_t pending_ranges [$];

    int unsigned items_sent;
    int unsigned loads_sent;
    int unsigned queries_sent;
    int unsigned results_checked;
    int unsigned length_settings;
    int unsigned fail_count;
    int unsigned cycle_count;

    // Idling controls. When a flag is set, that side runs without gaps.
    // A nonzero hold count makes the receiver drop ready for that many cycles.
    bit steady_send;
    bit steady_drain;
    int unsigned result_hold_cycles;

    function automatic void log_failure(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endfunction

    // Finds the lower bound (upper_side clear) or the upper bound (upper_side set)
    // within n entries that start at lo.
    function automatic int unsigned bound_search(int unsigned lo, int unsigned n,
                                                 logic [KEY_W-1:0] probe_key,
                                                 bit upper_side);
        int unsigned half;
        int unsigned mid;
        bit go_right;
        while (n > 0) begin
            half = n >> 1;
            mid = lo + half;
            go_right = upper_side ? !(probe_key < key_store[mid])
                                  : (key_store[mid] < probe_key);
            if (go_right) begin
                lo = mid + 1;
                n = n - half - 1;
            end else begin
                n = half;
            end
        end
        return lo;
    endfunction

    // Three-way binary search over the active part of the table. The first probe
    // that hits an equal key splits the work: a lower-bound search runs to its
    // left and an upper-bound search to its right. On an unsorted table this
    // still gives exactly what the hardware procedure gives.
    function automatic key_range_t predict_range(logic [KEY_W-1:0] probe_key);
        int unsigned base;
        int unsigned n;
        int unsigned half;
        int unsigned mid;
        key_range_t found;
        base = 0;
        // A length above the table depth saturates at the depth.
        n = (search_length > TABLE_DEPTH) ? TABLE_DEPTH : search_length;
        while (n > 0) begin
            half = n >> 1;
            mid = base + half;
            if (key_store[mid] < probe_key) begin
                base = mid + 1;
                n = n - half - 1;
            end else if (probe_key < key_store[mid]) begin
                n = half;
            end else begin
                found.lower_index = LEN_W'(bound_search(base, half, probe_key, 1'b0));
                found.upper_index = LEN_W'(bound_search(mid + 1, n - half - 1,
                                                        probe_key, 1'b1));
                return found;
            end
        end
        // No equal entry, so both bounds are the insertion point.
        found.lower_index = LEN_W'(base);
        found.upper_index = LEN_W'(base);
        return found;
    endfunction

    // Query keys lean toward keys that sit in the active part of the table and
    // their neighbors, so that hits, duplicate runs and near misses are common.
    function automatic logic [KEY_W-1:0] draw_probe_key(int unsigned active_entries);
        int unsigned choice;
        logic [KEY_W-1:0] picked;
        choice = $urandom_range(0, 9);
        if (active_entries != 0 && choice < 4) begin
            picked = key_store[$urandom_range(0, active_entries - 1)];
        end else if (active_entries != 0 && choice < 6) begin
            picked = key_store[$urandom_range(0, active_entries - 1)];
            picked = picked + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        end else if (choice == 6) begin
            picked = $urandom_range(0, 1) ? '0 : '1;
        end else begin
            picked = $urandom();
        end
        return picked;
    endfunction

    // Offers one item after a random gap and returns at the edge where it is
    // accepted. Valid stays high on return, so back-to-back items need no gap.
    task automatic transfer_item(input logic item_mode, input logic [SLOT_W-1:0] item_slot,
                                 input logic [KEY_W-1:0] item_key);
        int unsigned gap;
        gap = steady_send ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.mode  <= item_mode;
        item_if.slot  <= item_slot;
        item_if.key   <= item_key;
        do @(posedge i_clk);
        while (item_if.ready !== 1'b1);
        items_sent++;
        if (item_mode == MODE_QUERY) begin
            queries_sent++;
            pending_ranges.push_back(predict_range(item_key));
        end else begin
            loads_sent++;
            key_store[item_slot] = item_key;
        end
    endtask

    task automatic send_query(input int unsigned active_entries);
        transfer_item(MODE_QUERY, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)),
                      draw_probe_key(active_entries));
    endtask

    // Stops offering items and waits until every expected result has come back,
    // then lets the block settle so that no load is still being handled.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_search_length(input logic [LEN_W-1:0] length_value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= length_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        search_length = length_value;
        length_settings++;
    endtask

    // Straight after reset the length is zero, so every query is on an empty
    // table and answers zero without reading any entry.
    task automatic test_reset_length();
        transfer_item(MODE_QUERY, '1, 32'd5);
        transfer_item(MODE_QUERY, '0, 32'hFFFF_FFFF);
    endtask

    // A small table with duplicate runs at the low end and mid-range. The key
    // at the last slot lies outside the searched part and must not matter.
    task automatic test_duplicate_runs();
        transfer_item(MODE_LOAD, 10'd0, 32'd0);
        transfer_item(MODE_LOAD, 10'd1, 32'd0);
        transfer_item(MODE_LOAD, 10'd2, 32'd7);
        transfer_item(MODE_LOAD, 10'd3, 32'd7);
        transfer_item(MODE_LOAD, 10'd4, 32'd7);
        transfer_item(MODE_LOAD, 10'd5, 32'hFFFF_FFFF);
        transfer_item(MODE_LOAD, 10'd1023, 32'hA5A5_A5A5);
        set_search_length(LEN_W'(6));
        transfer_item(MODE_QUERY, '0, 32'd0);
        transfer_item(MODE_QUERY, '1, 32'd7);
        transfer_item(MODE_QUERY, 10'h155, 32'd3);
        transfer_item(MODE_QUERY, 10'h2AA, 32'd8);
        transfer_item(MODE_QUERY, '0, 32'hFFFF_FFFF);
    endtask

    // A length written back to zero empties the table again.
    task automatic test_empty_table();
        set_search_length('0);
        transfer_item(MODE_QUERY, '0, 32'd7);
    endtask

    // Breaking the order puts the largest key in the middle of the table.
    task automatic test_unsorted_table();
        transfer_item(MODE_LOAD, 10'd2, 32'hFFFF_FFFF);
        set_search_length(LEN_W'(6));
        transfer_item(MODE_QUERY, '0, 32'd7);
        transfer_item(MODE_QUERY, '0, 32'd0);
    endtask

    // Loads all entries with ascending keys. About a quarter of the steps are
    // zero, which gives duplicate runs, and the top is clamped at the largest key.
    // Then the whole table is searched, once with the length that saturates.
    task automatic test_full_table();
        logic [63:0] running;
        running = '0;
        for (int idx = 0; idx < TABLE_DEPTH; idx++) begin
            if ($urandom_range(0, 3) != 0) running += $urandom_range(0, 1 << 23);
            if (running > 64'hFFFF_FFFF) running = 64'hFFFF_FFFF;
            transfer_item(MODE_LOAD, SLOT_W'(idx), running[KEY_W-1:0]);
        end
        set_search_length(LEN_W'(TABLE_DEPTH));
        repeat (60) send_query(TABLE_DEPTH);
        set_search_length('1);
        repeat (40) send_query(TABLE_DEPTH);
    endtask

    // The receiver holds off for a long stretch while queries keep coming with
    // no gaps. The output register and the search in progress fill up, and the
    // input has to stall until the receiver lets results go again.
    task automatic test_result_backpressure();
        set_search_length(LEN_W'(TABLE_DEPTH));
        steady_send = 1'b1;
        result_hold_cycles = 400;
        repeat (12) send_query(TABLE_DEPTH);
        steady_send = 1'b0;
        wait_idle();
    endtask

    // Each phase sets up a table, writes a length while idle and then runs a
    // burst of queries with a few stray loads. Most phases rewrite a short
    // prefix with sorted keys that stay below the entry just past the prefix,
    // so that the whole table stays in order. Some write an unsorted prefix and
    // some search long or saturating lengths over whatever the table holds.
    task automatic test_random_phases();
        int unsigned kind;
        int unsigned len;
        int unsigned active_entries;
        int unsigned step;
        int unsigned burst;
        logic [KEY_W-1:0] next_key;
        while (items_sent < ITEM_GOAL) begin
            steady_send  = ($urandom_range(0, 3) == 0);
            steady_drain = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = (kind < 2) ? $urandom_range(0, 4) : $urandom_range(1, 48);
                step = key_store[len] / (len + 1);
                next_key = $urandom_range(0, step);
                for (int idx = 0; idx < len; idx++) begin
                    transfer_item(MODE_LOAD, SLOT_W'(idx), next_key);
                    if ($urandom_range(0, 9) >= 3) next_key += $urandom_range(0, step);
                end
            end else if (kind == 7) begin
                len = $urandom_range(2, 16);
                for (int idx = 0; idx < len; idx++) begin
                    transfer_item(MODE_LOAD, SLOT_W'(idx), $urandom());
                end
            end else begin
                len = $urandom_range(49, (1 << LEN_W) - 1);
            end
            set_search_length(LEN_W'(len));
            active_entries = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
            burst = $urandom_range(12, 30);
            repeat (burst) begin
                // Stray loads may land anywhere, since every entry is written by now.
                if ($urandom_range(0, 19) == 0) begin
                    transfer_item(MODE_LOAD, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                  $urandom());
                end else begin
                    send_query(active_entries);
                end
            end
        end
        steady_send  = 1'b0;
        steady_drain = 1'b0;
    endtask

    // Result receiver. Before each result it draws a pause with ready low, and a
    // requested long hold replaces that pause. A hold request also cuts short a
    // wait for a result, so that the hold starts even when nothing is pending.
    initial begin : result_receiver
        int unsigned pause;
        result_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (result_hold_cycles != 0) begin
                pause = result_hold_cycles;
                result_hold_cycles = 0;
            end else begin
                pause = steady_drain ? 0 : $urandom_range(0, 17);
            end
            if (pause != 0) begin
                result_if.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(result_if.valid === 1'b1 && result_if.ready === 1'b1)
                   && result_hold_cycles == 0);
        end
    end

    // Result checker. Every transfer is matched with the oldest expected range.
    always @(posedge i_clk) begin : result_check
        key_range_t expected_range;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_ranges.size() == 0) begin
                log_failure($sformatf("result lower %0d upper %0d with no query pending",
                                      result_if.lower_index, result_if.upper_index));
            end else begin
                expected_range = pending_ranges.pop_front();
                results_checked++;
                if (result_if.lower_index !== expected_range.lower_index
                    || result_if.upper_index !== expected_range.upper_index) begin
                    log_failure($sformatf(
                        "expected lower %0d upper %0d, got lower %0d upper %0d",
                        expected_range.lower_index, expected_range.upper_index,
                        result_if.lower_index, result_if.upper_index));
                end
            end
        end
    end

    // Watchdog. A hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_ranges.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        steady_send        = 1'b0;
        steady_drain       = 1'b0;
        result_hold_cycles = 0;
        items_sent         = 0;
        loads_sent         = 0;
        queries_sent       = 0;
        results_checked    = 0;
        length_settings    = 0;
        fail_count         = 0;
        cycle_count        = 0;
        search_length      = '0;
        for (int idx = 0; idx < TABLE_DEPTH; idx++) key_store[idx] = '0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        item_if.valid <= 1'b0;
        item_if.mode  <= MODE_LOAD;
        item_if.slot  <= '0;
        item_if.key   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_length();
        test_duplicate_runs();
        test_empty_table();
        test_unsorted_table();
        test_full_table();
        test_result_backpressure();
        test_random_phases();
        wait_idle();

        $display("Sent %0d loads and %0d queries, checked %0d results over %0d lengths,",
                 loads_sent, queries_sent, results_checked, length_settings);
        $display("including empty, full, saturated and unsorted tables and a long stall.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures", fail_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ster_pkg.sv
hdl/ster_in_if.sv
hdl/ster_out_if.sv
hdl/sorted_table_equal_range.sv
bench/sorted_table_equal_range_tb.sv
